FILE: sv/bfdh_pkg.sv
// ----------------------------------------------------------------------------
// bfdh_pkg: shared types and constants for the double-hash Bloom filter
// Holds the store size, the hash seeds and the record that is passed from the
// key hasher to the probe engine.
// ----------------------------------------------------------------------------
package bfdh_pkg;

  localparam int unsigned BIT_CAPACITY = 1048576;
  localparam int unsigned MAX_PROBES   = 32;
  localparam int unsigned ADDR_W       = $clog2(BIT_CAPACITY);
  localparam int unsigned CNT_W        = ADDR_W + 1;
  localparam int unsigned PRB_W        = $clog2(MAX_PROBES + 1);

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam logic [63:0] DJB_SEED  = 64'd5381;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic REG_BIT_COUNT   = 1'b0;
  localparam logic REG_PROBE_COUNT = 1'b1;

  // One finished key, waiting for its probes.
  typedef struct packed {
    logic        action;
    logic [63:0] hash_a;
    logic [63:0] hash_b;
  } key_rec_t;

endpackage

FILE: sv/bfdh_front.sv
// ----------------------------------------------------------------------------
// bfdh_front: key hasher
// Folds key bytes into FNV-1a and djb2 hashes and pushes one record per key
// into a small queue that feeds the probe engine.
// ----------------------------------------------------------------------------
module bfdh_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               action,
  input  logic [7:0]         key_byte,
  input  logic               byte_present,
  input  logic               key_last,
  output logic               rec_valid,
  output bfdh_pkg::key_rec_t rec,
  input  logic               rec_take
);
  import bfdh_pkg::*;

  // The FNV multiply is done in its own state after the byte state: the byte
  // state xors, then the product is formed from a shift plus a narrow multiply.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;

  logic [1:0]  state;
  logic [63:0] hash_a;
  logic [63:0] hash_b;
  logic [63:0] xored;
  logic        pend_last;
  logic        pend_act;

  // Two-entry queue of finished keys.
  key_rec_t    q_mem [2];
  logic        q_wp;
  logic        q_rp;
  logic [1:0]  q_cnt;
  logic        q_push;
  key_rec_t    q_in;
  logic [63:0] prod;

  // FNV prime = 2^40 + 0x1b3: shift plus a narrow multiply.
  assign prod = (xored << 40) + (xored * 64'h1b3);

  // Accept only when idle and the queue can hold a key that may finish now.
  assign full = (state != ST_IDLE) || (q_cnt == 2'd2);

  always_comb begin
    q_push = 1'b0;
    q_in   = '{action: pend_act, hash_a: prod, hash_b: hash_b};
    if (state == ST_MUL && pend_last) begin
      q_push = 1'b1;
    end else if (state == ST_IDLE && push && !full && key_last && !byte_present) begin
      q_push = 1'b1;
      q_in   = '{action: action, hash_a: hash_a, hash_b: hash_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      hash_a <= FNV_BASIS;
      hash_b <= DJB_SEED;
    end else begin
      case (state)
        ST_IDLE: begin
          if (push && !full) begin
            pend_last <= key_last;
            pend_act  <= action;
            if (byte_present) begin
              xored  <= hash_a ^ {56'd0, key_byte};
              hash_b <= (hash_b << 5) + hash_b + {56'd0, key_byte};
              state  <= ST_MUL;
            end else if (key_last) begin
              hash_a <= FNV_BASIS;
              hash_b <= DJB_SEED;
            end
          end
        end
        ST_MUL: begin
          state <= ST_IDLE;
          if (pend_last) begin
            hash_a <= FNV_BASIS;
            hash_b <= DJB_SEED;
          end else begin
            hash_a <= prod;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) q_mem[q_wp] <= q_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wp  <= 1'b0;
      q_rp  <= 1'b0;
      q_cnt <= 2'd0;
    end else begin
      if (q_push) q_wp <= ~q_wp;
      if (rec_take) q_rp <= ~q_rp;
      q_cnt <= q_cnt + {1'b0, q_push} - {1'b0, rec_take};
    end
  end

  assign rec_valid = (q_cnt != 2'd0);
  assign rec       = q_mem[q_rp];
endmodule

FILE: sv/bfdh_mod.sv
// ----------------------------------------------------------------------------
// bfdh_mod: 64-bit by 21-bit remainder
// Restoring division, one quotient bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module bfdh_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [63:0]               dividend,
  input  logic [bfdh_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [bfdh_pkg::ADDR_W-1:0] remainder
);
  import bfdh_pkg::*;

  logic             busy;
  logic [63:0]      num;
  logic [CNT_W-1:0] div;
  logic [CNT_W:0]   rem;
  logic [6:0]       steps;
  logic [CNT_W:0]   trial;

  assign trial     = {rem[CNT_W-1:0], num[63]};
  assign remainder = rem[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        num   <= dividend;
        div   <= divisor;
        rem   <= '0;
        steps <= 7'd64;
      end else if (busy) begin
        num <= {num[62:0], 1'b0};
        if (trial >= {1'b0, div}) rem <= trial - {1'b0, div};
        else rem <= trial;
        steps <= steps - 7'd1;
        if (steps == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: sv/bfdh_back.sv
// ----------------------------------------------------------------------------
// bfdh_back: probe engine
// Walks the probes of one key: computes each index, reads or sets the bit in
// the store, and pushes the result into a two-entry output queue. A sweep
// after reset clears the store.
// ----------------------------------------------------------------------------
module bfdh_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [20:0]        bit_count,
  input  logic [5:0]         probe_count,
  input  logic               rec_valid,
  input  bfdh_pkg::key_rec_t rec,
  output logic               rec_take,
  output logic               empty,
  input  logic               pop,
  output logic               done_action,
  output logic               maybe_present
);
  import bfdh_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic [63:0]       probe_val;
  logic [63:0]       step_val;
  logic [PRB_W-1:0]  probe_idx;
  logic [PRB_W-1:0]  probes;
  logic [CNT_W-1:0]  modulus;
  logic              act;
  logic              all_set;
  logic              mod_start;
  logic              mod_done;
  logic [ADDR_W-1:0] mod_rem;
  logic              mem [BIT_CAPACITY];
  logic              rd_bit;

  logic              oq_val [2];
  logic              oq_act [2];
  logic              oq_wp;
  logic              oq_rp;
  logic [1:0]        oq_cnt;
  logic              oq_push;

  bfdh_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (probe_val),
    .divisor   (modulus),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign rec_take  = (state == ST_IDLE) && rec_valid && (oq_cnt != 2'd2);
  assign mod_start = (state == ST_DIV);
  assign oq_push   = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) mem[clr_addr] <= 1'b0;
    else if (state == ST_WAIT && mod_done && act == ACT_ADD) mem[mod_rem] <= 1'b1;
    if (state == ST_WAIT && mod_done) rd_bit <= mem[mod_rem];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(BIT_CAPACITY - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (rec_take) begin
            act       <= rec.action;
            probe_val <= rec.hash_a;
            step_val  <= rec.hash_b;
            probe_idx <= '0;
            all_set   <= 1'b1;
            if (bit_count == 21'd0) modulus <= CNT_W'(1);
            else if (bit_count > 21'(BIT_CAPACITY)) modulus <= CNT_W'(BIT_CAPACITY);
            else modulus <= CNT_W'(bit_count);
            probes <= (probe_count > 6'(MAX_PROBES)) ? PRB_W'(MAX_PROBES)
                                                     : PRB_W'(probe_count);
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (probe_idx == probes || !all_set) state <= ST_OUT;
          else state <= ST_DIV;
        end
        ST_DIV:  state <= ST_WAIT;
        ST_WAIT: begin
          if (mod_done) begin
            probe_val <= probe_val + step_val;
            probe_idx <= probe_idx + 1'b1;
            state     <= ST_READ;
          end
        end
        ST_READ: begin
          if (act == ACT_QUERY && !rd_bit) all_set <= 1'b0;
          state <= ST_CHECK;
        end
        ST_OUT:  state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_act[oq_wp] <= act;
      oq_val[oq_wp] <= (act == ACT_ADD) ? 1'b1 : all_set;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp  <= 1'b0;
      oq_rp  <= 1'b0;
      oq_cnt <= 2'd0;
    end else begin
      if (oq_push) oq_wp <= ~oq_wp;
      if (pop && !empty) oq_rp <= ~oq_rp;
      oq_cnt <= oq_cnt + {1'b0, oq_push} - {1'b0, pop && !empty};
    end
  end

  assign empty         = (oq_cnt == 2'd0);
  assign done_action   = oq_act[oq_rp];
  assign maybe_present = oq_val[oq_rp];
endmodule

FILE: sv/bloom_filter_double_hash.sv
// ----------------------------------------------------------------------------
// bloom_filter_double_hash: Bloom filter over byte-string keys
// Keys arrive one byte per item and are hashed with FNV-1a and djb2; at the
// end of a key the probes (hashA + i*hashB) mod bit_count set or test bits.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   input     push / full        action, key_byte, byte_present, key_last
//   result    pop / empty        done_action, maybe_present
//   config    cfg_we             cfg_index, cfg_data
//
// A present key byte is xored and added in the hasher and then goes through the
// FNV multiply; an absent byte skips the multiply. Each probe waits on the
// bit-serial 64-bit remainder unit, so a finished key holds the probe engine
// until its probe walk ends; a two-entry queue lets the hasher run ahead.
// After reset a clearing sweep zeroes the store; key bytes are still
// hashed meanwhile, but no probe starts until the sweep ends. A full result
// queue stalls the probe engine, and then the hasher.
module bloom_filter_double_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [7:0]  key_byte,
  input  logic        byte_present,
  input  logic        key_last,
  output logic        empty,
  input  logic        pop,
  output logic        done_action,
  output logic        maybe_present,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [20:0] cfg_data
);
  import bfdh_pkg::*;

  logic [20:0] bit_count;
  logic [5:0]  probe_count;
  logic        rec_valid;
  logic        rec_take;
  key_rec_t    rec;

  // Configuration registers; writes must arrive only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count   <= 21'd1048576 & 21'h1FFFFF;
      probe_count <= 6'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_COUNT:   bit_count   <= cfg_data;
        REG_PROBE_COUNT: probe_count <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  bfdh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .action       (action),
    .key_byte     (key_byte),
    .byte_present (byte_present),
    .key_last     (key_last),
    .rec_valid    (rec_valid),
    .rec          (rec),
    .rec_take     (rec_take)
  );

  bfdh_back u_back (
    .clk           (clk),
    .rst           (rst),
    .bit_count     (bit_count),
    .probe_count   (probe_count),
    .rec_valid     (rec_valid),
    .rec           (rec),
    .rec_take      (rec_take),
    .empty         (empty),
    .pop           (pop),
    .done_action   (done_action),
    .maybe_present (maybe_present)
  );
endmodule

FILE: bench/tb_bloom_filter_double_hash.sv
// ----------------------------------------------------------------------------
// tb_bloom_filter_double_hash: self-checking bench for the Bloom filter
// Streams byte keys into the filter as adds and queries, keeps its own copy
// of the hashes and the bit store, and compares every answer, field by field,
// with the answer the copy predicts.
// ----------------------------------------------------------------------------
module tb_bloom_filter_double_hash;
  import bfdh_pkg::*;

  // One finished key as the checker expects to see it.
  typedef struct {
    logic act;
    logic maybe;
  } answer_t;

  // A key kept for reuse, so that later queries can hit earlier adds.
  typedef struct {
    logic [7:0] bytes [8];
    int         len;
  } key_t;

  // The clearing sweep after reset visits every bit of the store, so the
  // watchdog has to give well more than that before it calls a hang.
  localparam int STALL_LIMIT = 4000000;
  localparam int SETTLE      = 64;
  localparam int ANS_DEPTH   = 1024;
  localparam int POOL_DEPTH  = 256;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        action = 1'b0;
  logic [7:0]  key_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        key_last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        done_action;
  logic        maybe_present;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_BIT_COUNT;
  logic [20:0] cfg_data = '0;

  bloom_filter_double_hash dut (.*);

  always #5 clk = ~clk;

  // Shadow of the filter: the store, the running hashes and both registers.
  bit          store_copy [BIT_CAPACITY];
  logic [63:0] fnv_run = FNV_BASIS;
  logic [63:0] djb_run = DJB_SEED;
  logic [20:0] bit_count_reg = 21'd1048576;
  logic [5:0]  probe_count_reg = 6'd7;

  // Expected answers in order, as a ring with free-running head and tail.
  answer_t answer_ring [ANS_DEPTH];
  int      ans_head = 0;
  int      ans_tail = 0;
  key_t    key_pool [POOL_DEPTH];
  int      pool_size = 0;

  int errors = 0;
  int items_sent = 0;
  int answers_checked = 0;
  int positive_queries = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  // Runs the probes of one finished key against the shadow store and gives
  // back the answer the filter must report.
  function automatic logic run_probes(logic act);
    logic [63:0] modulus;
    logic [63:0] probes;
    logic [63:0] idx;
    logic        all_set;
    modulus = bit_count_reg;
    if (modulus == 0) modulus = 1;
    if (modulus > BIT_CAPACITY) modulus = BIT_CAPACITY;
    probes = probe_count_reg;
    if (probes > MAX_PROBES) probes = MAX_PROBES;
    all_set = 1'b1;
    for (logic [63:0] i = 0; i < probes; i++) begin
      idx = (fnv_run + i * djb_run) % modulus;
      if (act == ACT_ADD) begin
        store_copy[idx] = 1'b1;
      end else if (!store_copy[idx]) begin
        all_set = 1'b0;
        break;
      end
    end
    return (act == ACT_ADD) ? 1'b1 : all_set;
  endfunction

  // Folds one accepted item into the shadow and queues an answer at key end.
  task automatic absorb_item(logic act, logic [7:0] b, logic present, logic last);
    answer_t a;
    if (present) begin
      fnv_run = (fnv_run ^ {56'd0, b}) * FNV_PRIME;
      djb_run = djb_run * 64'd33 + {56'd0, b};
    end
    if (last) begin
      a.act = act;
      a.maybe = run_probes(act);
      if (act == ACT_QUERY && a.maybe) positive_queries++;
      answer_ring[ans_tail % ANS_DEPTH] = a;
      ans_tail++;
      fnv_run = FNV_BASIS;
      djb_run = DJB_SEED;
    end
  endtask

  // Offers one item and returns at the falling edge after it was taken.
  // The sender may idle first; push is assigned once per falling edge.
  task automatic send_item(logic act, logic [7:0] b, logic present, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    action <= act;
    key_byte <= b;
    byte_present <= present;
    key_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    absorb_item(act, b, present, last);
    items_sent++;
    @(negedge clk);
  endtask

  // Sends a whole key. Only the action of the final item counts, so the
  // earlier items carry random actions. Now and then an absent byte is slipped
  // into the middle; it must leave the hashes alone.
  task automatic send_key(logic act, key_t k);
    if (k.len == 0) begin
      send_item(act, 8'($urandom), 1'b0, 1'b1);
    end else begin
      for (int j = 0; j < k.len; j++) begin
        if (j > 0 && $urandom_range(9) == 0)
          send_item(1'($urandom), 8'($urandom), 1'b0, 1'b0);
        send_item((j == k.len - 1) ? act : 1'($urandom), k.bytes[j], 1'b1,
                  j == k.len - 1);
      end
    end
    if (act == ACT_ADD && pool_size < POOL_DEPTH) begin
      key_pool[pool_size] = k;
      pool_size++;
    end
  endtask

  function automatic key_t random_key();
    key_t k;
    k.len = $urandom_range(5);
    if ($urandom_range(15) == 0) k.len = 8;
    for (int j = 0; j < 8; j++) k.bytes[j] = 8'($urandom);
    return k;
  endfunction

  // Mostly reuse earlier adds, so queries hit and adds overlap; otherwise a
  // fresh key, which a query usually misses.
  task automatic send_random_key();
    key_t k;
    if (pool_size > 0 && $urandom_range(99) < 55)
      k = key_pool[$urandom_range(pool_size - 1)];
    else
      k = random_key();
    send_key(1'($urandom), k);
  endtask

  // Waits for every pending answer, then lets the probe engine settle.
  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (ans_tail != ans_head) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Register write; only issued while the filter is idle.
  task automatic write_reg(logic idx, logic [20:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BIT_COUNT) bit_count_reg = data;
    else probe_count_reg = data[5:0];
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  // Empty keys, absent bytes, extreme byte values, a miss before any add,
  // and a query of a key that was just added.
  task automatic test_directed();
    key_t k;
    k.len = 0;
    for (int j = 0; j < 8; j++) k.bytes[j] = 8'hFF;
    send_key(ACT_QUERY, k);
    send_key(ACT_ADD, k);
    send_key(ACT_QUERY, k);
    k.len = 3;
    k.bytes[0] = 8'h00;
    k.bytes[1] = 8'hFF;
    k.bytes[2] = 8'hA5;
    send_key(ACT_QUERY, k);
    send_key(ACT_ADD, k);
    send_key(ACT_QUERY, k);
    // The same key with an absent byte in the middle hashes the same way.
    send_item(ACT_ADD, 8'h00, 1'b1, 1'b0);
    send_item(ACT_ADD, 8'h5A, 1'b0, 1'b0);
    send_item(ACT_QUERY, 8'hFF, 1'b1, 1'b0);
    send_item(ACT_QUERY, 8'hA5, 1'b1, 1'b1);
    // An absent byte may also finish a key.
    send_item(ACT_ADD, 8'h00, 1'b1, 1'b0);
    send_item(ACT_QUERY, 8'h3C, 1'b0, 1'b1);
    k.len = 8;
    for (int j = 0; j < 8; j++) k.bytes[j] = 8'h80 >> j;
    send_key(ACT_QUERY, k);
    drain();
  endtask

  // Walks the registers through their corners, including a zero bit count, a
  // count far above the capacity, zero probes and more probes than allowed.
  task automatic test_register_corners();
    logic [20:0] bit_counts [6]   = '{21'd1, 21'd0, 21'h1FFFFF, 21'd64, 21'd37,
                                      21'd1000};
    logic [20:0] probe_counts [6] = '{21'd3, 21'd2, 21'd4, 21'd0, 21'h1FFFFF,
                                      21'h1FFFE0};
    for (int s = 0; s < 6; s++) begin
      write_reg(REG_BIT_COUNT, bit_counts[s]);
      write_reg(REG_PROBE_COUNT, probe_counts[s]);
      for (int n = 0; n < 10; n++) send_random_key();
      drain();
    end
  endtask

  // The receiver stops for a long stretch while one-probe keys keep coming,
  // so the result side fills up and the input stalls.
  task automatic test_backpressure();
    write_reg(REG_BIT_COUNT, 21'd4096);
    write_reg(REG_PROBE_COUNT, 21'd1);
    hold_request = 4000;
    for (int n = 0; n < 40; n++) send_random_key();
    drain();
  endtask

  // Random keys under one idling pattern and one register setting.
  task automatic test_random(int s_idle, int r_idle, logic [20:0] bits,
                             logic [20:0] probes, int items);
    int start;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    write_reg(REG_BIT_COUNT, bits);
    write_reg(REG_PROBE_COUNT, probes);
    start = items_sent;
    while (items_sent - start < items) send_random_key();
    drain();
  endtask

  // --------------------------------------------------------------- checker

  // Receiver: draws a fresh pop every cycle unless a long hold is running.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
    end
    if (rst) pop <= 1'b0;
    else pop <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    answer_t a;
    if (!rst && pop && !empty) begin
      if (ans_tail == ans_head) begin
        $display("%0t: unexpected answer, action %0b maybe %0b", $time,
                 done_action, maybe_present);
        errors++;
      end else begin
        a = answer_ring[ans_head % ANS_DEPTH];
        ans_head++;
        answers_checked++;
        if (done_action !== a.act) begin
          $display("%0t: done_action expected %0b actual %0b", $time, a.act,
                   done_action);
          errors++;
        end
        if (maybe_present !== a.maybe) begin
          $display("%0t: maybe_present expected %0b actual %0b", $time,
                   a.maybe, maybe_present);
          errors++;
        end
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d answers outstanding",
               $time, quiet_cycles, ans_tail - ans_head);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_register_corners();
    test_backpressure();
    test_random(19, 72, 21'd4096, 21'd4, 400);
    test_random(72, 19, 21'd100, 21'd6, 400);
    test_random(0, 0, 21'd1048576, 21'd7, 400);
    repeat (200) @(negedge clk);
    if (ans_tail != ans_head) begin
      $display("%0t: %0d expected answers never arrived", $time,
               ans_tail - ans_head);
      errors++;
    end
    $display("Sent %0d items, checked %0d answers (%0d positive queries)",
             items_sent, answers_checked, positive_queries);
    $display("Covered register corners, idling patterns and a long result stall.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
